/* hdl/tird_pkg.sv */
`timescale 1ns / 1ps

package tird_pkg;

    localparam int unsigned HDR_BYTES = 12;
    localparam int unsigned CNT_W     = $clog2(HDR_BYTES);

    // Walk phases
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_RECORD = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EOF     = 3'd1;
    localparam logic [2:0] ST_UEOF    = 3'd2;
    localparam logic [2:0] ST_FATAL   = 3'd3;
    localparam logic [2:0] ST_FAILREC = 3'd4;
    localparam logic [2:0] ST_BADLEN  = 3'd5;

    // Header type values
    localparam logic [31:0] TYPE_RECORD = 32'd0;
    localparam logic [31:0] TYPE_FILE   = 32'd1;

    // One input item as held in the input register.
    typedef struct packed {
        logic       end_of_input;
        logic [7:0] data_byte;
    } t_item;

    // One result item.
    typedef struct packed {
        logic        recovery_active;
        logic [2:0]  status;
        logic        header_done;
        logic [31:0] logical_offset;
        logic        payload_valid;
        logic [7:0]  data_out;
    } t_result;

endpackage

/* hdl/tape_image_record_deframer_top.sv */
`timescale 1ns / 1ps

// Tape-image record deframer.
// The slave stream carries the raw file one byte per transfer; s_tlast set
// marks the end of the file and then the byte is ignored. Every input transfer
// yields exactly one result transfer on the master stream: the byte if it was
// record payload (with its logical offset), or a header/drop marker, plus the
// running status and the recovery flag. Headers are checked when their
// twelfth byte arrives; after a stop status every later transfer repeats it.
// The base position register is loaded through i_cfg_we / i_cfg_wdata; the user
// must load it only while the block is idle, as the block does not enforce it.
// An input transfer passes through the input register and then the result
// register before its result shows on m_tvalid, with all header checks done
// in the single logic step between them. Throughput is one byte per cycle
// while the receiver keeps m_tready high. When the receiver holds m_tready low
// the result register keeps its item, one more byte waits in the input
// register, and then s_tready drops until the master side moves again.
// Synchronous reset empties both registers and returns the walker to header
// collection with the base position, counters and the recovery flag at zero.
module tape_image_record_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] data_out, [39:8] logical_offset,
                                   // [42:40] status, [43] recovery_active, rest zero
    output logic [1:0]  m_tuser    // [0] payload_valid, [1] header_done
);
    import tird_pkg::*;

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    out_ready;
    logic    advance;
    t_result core_result;
    t_result out_result;

    assign in_item.data_byte    = s_tdata;
    assign in_item.end_of_input = s_tlast;

    assign advance = held_valid && out_ready;

    tird_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_tvalid),
        .o_ready   (s_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    tird_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (advance),
        .i_item      (held_item),
        .o_result    (core_result)
    );

    tird_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (held_valid),
        .o_ready  (out_ready),
        .i_result (core_result),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_result (out_result)
    );

    assign m_tdata = {4'b0000, out_result.recovery_active, out_result.status,
                      out_result.logical_offset, out_result.data_out};
    assign m_tuser = {out_result.header_done, out_result.payload_valid};

endmodule

/* hdl/tird_in_reg.sv */
`timescale 1ns / 1ps

module tird_in_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tird_pkg::t_item      i_item,
    input  logic                 i_advance,
    output logic                 o_valid,
    output tird_pkg::t_item      o_item
);
    import tird_pkg::*;

    logic  r_valid;
    t_item r_item;

    // The register takes a new byte when it is empty or its byte moves on this cycle.
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* hdl/tird_core.sv */
`timescale 1ns / 1ps

module tird_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata,
    input  logic                 i_step,
    input  tird_pkg::t_item      i_item,
    output tird_pkg::t_result    o_result
);
    import tird_pkg::*;

    logic [7:0]       r_hdr [HDR_BYTES-1];
    logic [CNT_W-1:0] r_cnt,      n_cnt;
    logic [31:0]      r_left,     n_left;
    logic [31:0]      r_last,     n_last;
    logic [31:0]      r_earlier,  n_earlier;
    logic [1:0]       r_seen,     n_seen;
    logic             r_rec,      n_rec;
    logic [1:0]       r_phase,    n_phase;
    logic [31:0]      r_logical,  n_logical;
    logic [2:0]       r_final,    n_final;
    logic [31:0]      r_base,     n_base;

    logic [31:0] hdr_type;
    logic [31:0] hdr_prev;
    logic [31:0] hdr_next;
    logic [33:0] rec_len;
    logic        hdr_write;

    // The last header byte is used straight from the input, never stored.
    always_comb begin
        hdr_type = {r_hdr[3], r_hdr[2], r_hdr[1], r_hdr[0]};
        hdr_prev = {r_hdr[7], r_hdr[6], r_hdr[5], r_hdr[4]};
        hdr_next = {i_item.data_byte, r_hdr[10], r_hdr[9], r_hdr[8]};
        rec_len  = {2'b00, hdr_next} - {2'b00, r_last} - 34'(HDR_BYTES);
    end

    assign hdr_write = i_step && (r_phase == PH_HEADER) && !i_item.end_of_input
                       && (r_cnt != CNT_W'(HDR_BYTES - 1));

    always_comb begin
        logic       stop;
        logic [2:0] st;

        n_cnt     = r_cnt;
        n_left    = r_left;
        n_last    = r_last;
        n_earlier = r_earlier;
        n_seen    = r_seen;
        n_rec     = r_rec;
        n_phase   = r_phase;
        n_logical = r_logical;
        n_final   = r_final;
        n_base    = r_base;
        stop      = 1'b0;
        st        = ST_OK;

        o_result                 = '0;
        o_result.logical_offset  = r_logical;

        if (i_step) begin
            if (r_phase == PH_DONE) begin
                st = r_final;
            end else if (i_item.end_of_input) begin
                st   = (r_phase == PH_HEADER && r_cnt == '0) ? ST_EOF : ST_UEOF;
                stop = 1'b1;
            end else if (r_phase == PH_RECORD) begin
                o_result.data_out      = i_item.data_byte;
                o_result.payload_valid = 1'b1;
                n_logical = r_logical + 32'd1;
                n_left    = r_left - 32'd1;
                if (r_left == 32'd1) begin
                    n_phase = PH_HEADER;
                end
            end else if (r_cnt != CNT_W'(HDR_BYTES - 1)) begin
                n_cnt = r_cnt + CNT_W'(1);
            end else begin
                n_cnt = '0;
                o_result.header_done = 1'b1;
                // Checks run in a fixed order; the first stopping one sets the status.
                if (hdr_type != TYPE_RECORD && hdr_type != TYPE_FILE) begin
                    if (n_rec) begin
                        stop = 1'b1;
                        st   = ST_FAILREC;
                    end else begin
                        n_rec = 1'b1;
                    end
                end
                if (!stop && hdr_next <= hdr_prev) begin
                    stop = 1'b1;
                    st   = ST_FATAL;
                end
                if (!stop) begin
                    if (r_seen >= 2'd2) begin
                        if (hdr_prev != r_earlier) begin
                            if (n_rec) begin
                                stop = 1'b1;
                                st   = ST_FAILREC;
                            end else begin
                                n_rec = 1'b1;
                            end
                        end
                    end else if (n_rec && r_seen == 2'd1 && hdr_prev != r_base) begin
                        stop = 1'b1;
                        st   = ST_FAILREC;
                    end
                end
                if (!stop && rec_len[33]) begin
                    stop = 1'b1;
                    st   = ST_BADLEN;
                end
                if (!stop) begin
                    n_earlier = r_last;
                    n_last    = hdr_next;
                    if (r_seen < 2'd2) begin
                        n_seen = r_seen + 2'd1;
                    end
                    if (hdr_type == TYPE_FILE) begin
                        stop = 1'b1;
                        st   = ST_EOF;
                    end else begin
                        n_left  = rec_len[31:0];
                        n_phase = (rec_len[31:0] == 32'd0) ? PH_HEADER : PH_RECORD;
                    end
                end
            end
            if (stop) begin
                n_phase = PH_DONE;
                n_final = st;
            end
        end

        if (i_cfg_we) begin
            n_base = i_cfg_wdata;
            if (r_seen == 2'd0) begin
                n_last    = i_cfg_wdata;
                n_earlier = i_cfg_wdata;
            end
        end

        o_result.status          = st;
        o_result.recovery_active = n_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_left    <= '0;
            r_last    <= '0;
            r_earlier <= '0;
            r_seen    <= '0;
            r_rec     <= 1'b0;
            r_phase   <= PH_HEADER;
            r_logical <= '0;
            r_final   <= ST_OK;
            r_base    <= '0;
        end else begin
            r_cnt     <= n_cnt;
            r_left    <= n_left;
            r_last    <= n_last;
            r_earlier <= n_earlier;
            r_seen    <= n_seen;
            r_rec     <= n_rec;
            r_phase   <= n_phase;
            r_logical <= n_logical;
            r_final   <= n_final;
            r_base    <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hdr_write) begin
            r_hdr[r_cnt] <= i_item.data_byte;
        end
    end

endmodule

/* hdl/tird_out_reg.sv */
`timescale 1ns / 1ps

module tird_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tird_pkg::t_result    i_result,
    output logic                 o_valid,
    input  logic                 i_ready,
    output tird_pkg::t_result    o_result
);
    import tird_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* verif/tape_image_record_deframer_top_tb.sv */
`timescale 1ns / 1ps

module tape_image_record_deframer_top_tb;
    import tird_pkg::*;

    localparam logic [31:0] DIR_BASE  = 32'h0000_0100;
    localparam t_result     NO_EXP    = '0;
    localparam int          DIR_ROWS  = 27;
    localparam int          RAND_BYTES = 800;

    typedef struct packed {
        t_item   item;
        logic    typed;
        t_result want;
    } dir_row_t;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_wdata = 32'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'd0;  // [7:0] data_byte
    logic        s_tlast     = 1'b0;  // end_of_input
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [47:0] m_tdata;             // [7:0] data_out, [39:8] logical_offset,
                                      // [42:40] status, [43] recovery_active
    logic [1:0]  m_tuser;             // [0] payload_valid, [1] header_done

    tape_image_record_deframer_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // Predictor state of the deframer.
    logic [7:0]  hdr_buf [HDR_BYTES];
    int unsigned hdr_cnt;
    logic [31:0] rec_left;
    logic [31:0] last_next;
    logic [31:0] prior_next;
    int unsigned hdrs_seen;
    logic        in_recovery;
    logic [1:0]  walk;
    logic [31:0] pay_count;
    logic [2:0]  stop_st;
    logic [31:0] base_reg;

    t_result  deframed_q [$];
    t_item    feed_q [$];
    dir_row_t dir_tab [DIR_ROWS];
    int       fail_cnt  = 0;
    int       bytes_in  = 0;
    int       burst_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic t_result res(input logic [7:0] data, input logic valid,
                                    input logic [31:0] offs, input logic hdr,
                                    input logic [2:0] st);
        t_result r;
        r = '0;
        r.data_out       = data;
        r.payload_valid  = valid;
        r.logical_offset = offs;
        r.header_done    = hdr;
        r.status         = st;
        return r;
    endfunction

    function automatic dir_row_t row(input logic [7:0] data, input logic typed,
                                     input t_result want);
        dir_row_t d;
        d.item  = '{1'b0, data};
        d.typed = typed;
        d.want  = want;
        return d;
    endfunction

    function automatic void deframer_reset();
        for (int i = 0; i < HDR_BYTES; i++) hdr_buf[i] = 8'd0;
        hdr_cnt     = 0;
        rec_left    = 32'd0;
        last_next   = 32'd0;
        prior_next  = 32'd0;
        hdrs_seen   = 0;
        in_recovery = 1'b0;
        walk        = PH_HEADER;
        pay_count   = 32'd0;
        stop_st     = ST_OK;
        base_reg    = 32'd0;
    endfunction

    function automatic logic [2:0] halt(input logic [2:0] st);
        walk    = PH_DONE;
        stop_st = st;
        return st;
    endfunction

    function automatic logic [2:0] check_header();
        logic [31:0]        typ;
        logic [31:0]        prv;
        logic [31:0]        nxt;
        logic signed [33:0] len;
        typ = {hdr_buf[3], hdr_buf[2], hdr_buf[1], hdr_buf[0]};
        prv = {hdr_buf[7], hdr_buf[6], hdr_buf[5], hdr_buf[4]};
        nxt = {hdr_buf[11], hdr_buf[10], hdr_buf[9], hdr_buf[8]};
        if (typ != TYPE_RECORD && typ != TYPE_FILE) begin
            if (in_recovery) return halt(ST_FAILREC);
            in_recovery = 1'b1;
            typ = TYPE_RECORD;
        end
        if (nxt <= prv) return halt(ST_FATAL);
        if (hdrs_seen >= 2) begin
            if (prv != prior_next) begin
                if (in_recovery) return halt(ST_FAILREC);
                in_recovery = 1'b1;
            end
        end else if (in_recovery && hdrs_seen == 1) begin
            if (prv != base_reg) return halt(ST_FAILREC);
        end
        len = $signed({2'b00, nxt}) - $signed({2'b00, last_next}) - 34'sd12;
        if (len < 0) return halt(ST_BADLEN);
        prior_next = last_next;
        last_next  = nxt;
        if (hdrs_seen < 2) hdrs_seen++;
        if (typ == TYPE_FILE) return halt(ST_EOF);
        rec_left = len[31:0];
        walk = (rec_left == 32'd0) ? PH_HEADER : PH_RECORD;
        return ST_OK;
    endfunction

    function automatic t_result deframe_step(input t_item it);
        t_result r;
        r = '0;
        if (walk == PH_DONE) begin
            r.status = stop_st;
        end else if (it.end_of_input) begin
            r.status = halt((walk == PH_HEADER && hdr_cnt == 0) ? ST_EOF : ST_UEOF);
        end else if (walk == PH_RECORD) begin
            r.data_out      = it.data_byte;
            r.payload_valid = 1'b1;
        end else begin
            hdr_buf[hdr_cnt] = it.data_byte;
            hdr_cnt++;
            if (hdr_cnt == HDR_BYTES) begin
                hdr_cnt = 0;
                r.header_done = 1'b1;
                r.status = check_header();
            end
        end
        r.logical_offset = pay_count;
        if (r.payload_valid) begin
            pay_count++;
            rec_left--;
            if (rec_left == 32'd0) walk = PH_HEADER;
        end
        r.recovery_active = in_recovery;
        return r;
    endfunction

    // Called just after the clock rises; returns as soon as the transfer is
    // taken, with s_tvalid still high.
    task automatic send_item(input t_item it, input logic typed, input t_result want);
        int      gap;
        t_result r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= 8'($urandom_range(0, 255));
                s_tlast  <= 1'($urandom_range(0, 1));
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= it.data_byte;
        s_tlast  <= it.end_of_input;
        do @(posedge i_clk); while (!s_tready);
        bytes_in++;
        r = deframe_step(it);
        deframed_q.insert(deframed_q.size(), typed ? want : r);
    endtask

    task automatic send_feed();
        t_item it;
        while (feed_q.size() > 0) begin
            it = feed_q.pop_front();
            send_item(it, 1'b0, NO_EXP);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [31:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= $urandom;
        base_reg = v;
        if (hdrs_seen == 0) begin
            last_next  = v;
            prior_next = v;
        end
        @(posedge i_clk);
    endtask

    task automatic push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) feed_q.insert(feed_q.size(), '{1'b0, w[8*i +: 8]});
    endtask

    task automatic push_bytes(input int n);
        for (int i = 0; i < n; i++)
            feed_q.insert(feed_q.size(), '{1'b0, 8'($urandom_range(0, 255))});
    endtask

    task automatic push_eoi();
        feed_q.insert(feed_q.size(), '{1'b1, 8'($urandom_range(0, 255))});
    endtask

    // A header that chains onto the current pointers, optionally with its back
    // pointer moved off by skew, followed by body bytes of a len-byte record.
    task automatic push_record(input logic [31:0] typ, input logic [31:0] skew,
                               input int len, input int body);
        logic [31:0] prv;
        prv = ((hdrs_seen >= 2) ? prior_next : base_reg) + skew;
        push_word(typ);
        push_word(prv);
        push_word(last_next + 32'd12 + 32'(len));
        push_bytes(body);
    endtask

    function automatic logic [31:0] odd_type();
        logic [31:0] t;
        t = $urandom;
        if (t < 2) t = t + 2;
        return t;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3) return 0;
        if (r == 19) return $urandom_range(100, 250);
        return $urandom_range(1, 30);
    endfunction

    function automatic logic [31:0] pick_base();
        case ($urandom_range(0, 2))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_cnt++;
        end
    endtask

    // Receiver: random ready modes, plus one long hold-off to back up the block.
    int   rx_cyc    = 0;
    int   hold_left = 0;
    int   rx_mode   = 0;
    logic rdy;
    always @(posedge i_clk) begin
        rx_cyc++;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (rx_cyc == 500) begin
            hold_left = 80;
            rdy = 1'b0;
        end else begin
            if (rx_cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0:       rdy = 1'b1;
                1:       rdy = $urandom_range(0, 1);
                2:       rdy = ($urandom_range(0, 3) == 0);
                default: rdy = ($urandom_range(0, 7) != 0);
            endcase
        end
        m_tready <= rdy;
    end

    t_result want_r;
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (deframed_q.size() == 0) begin
                $error("unexpected result transfer: tdata %0h tuser %0h", m_tdata, m_tuser);
                fail_cnt++;
            end else begin
                want_r = deframed_q.pop_front();
                check_field("data_out", 32'(want_r.data_out), 32'(m_tdata[7:0]));
                check_field("payload_valid", 32'(want_r.payload_valid), 32'(m_tuser[0]));
                check_field("logical_offset", want_r.logical_offset, m_tdata[39:8]);
                check_field("header_done", 32'(want_r.header_done), 32'(m_tuser[1]));
                check_field("status", 32'(want_r.status), 32'(m_tdata[42:40]));
                check_field("recovery_active", 32'(want_r.recovery_active),
                            32'(m_tdata[43]));
                check_field("tdata_pad", 32'd0, 32'(m_tdata[47:44]));
            end
        end
    end

    initial begin
        int          start_cnt;
        int          len;
        int          k;
        int          recov_kind;
        int          recov_at;
        int          end_kind;
        int          next_cfg;
        bit          recov_done;
        logic [31:0] prv;

        deframer_reset();
        // Two records after a base of 0x100: a three-byte record with the
        // byte extremes, then an empty record.
        dir_tab = '{
            row(8'h00, 1'b1, res(8'h00, 1'b0, 32'd0, 1'b0, ST_OK)),
            row(8'h00, 1'b0, NO_EXP), row(8'h00, 1'b0, NO_EXP), row(8'h00, 1'b0, NO_EXP),
            row(8'h00, 1'b0, NO_EXP), row(8'h00, 1'b0, NO_EXP), row(8'h00, 1'b0, NO_EXP),
            row(8'h00, 1'b0, NO_EXP), row(8'h0F, 1'b0, NO_EXP), row(8'h01, 1'b0, NO_EXP),
            row(8'h00, 1'b0, NO_EXP),
            row(8'h00, 1'b1, res(8'h00, 1'b0, 32'd0, 1'b1, ST_OK)),
            row(8'h00, 1'b1, res(8'h00, 1'b1, 32'd0, 1'b0, ST_OK)),
            row(8'hFF, 1'b1, res(8'hFF, 1'b1, 32'd1, 1'b0, ST_OK)),
            row(8'h80, 1'b0, NO_EXP),
            row(8'h00, 1'b0, NO_EXP), row(8'h00, 1'b0, NO_EXP), row(8'h00, 1'b0, NO_EXP),
            row(8'h00, 1'b0, NO_EXP),
            row(8'h0F, 1'b0, NO_EXP), row(8'h01, 1'b0, NO_EXP), row(8'h00, 1'b0, NO_EXP),
            row(8'h00, 1'b0, NO_EXP),
            row(8'h1B, 1'b0, NO_EXP), row(8'h01, 1'b0, NO_EXP), row(8'h00, 1'b0, NO_EXP),
            row(8'h00, 1'b1, res(8'h00, 1'b0, 32'd3, 1'b1, ST_OK))
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cfg_write(32'hFFFF_FFFF);
        cfg_write(32'h0000_0000);
        cfg_write(DIR_BASE);

        for (int i = 0; i < DIR_ROWS; i++)
            send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
        drain();
        cfg_write(pick_base());

        // Random part: chained records, at most one recoverable fault, then
        // one way of ending the stream.
        recov_kind = $urandom_range(0, 2);
        recov_at   = $urandom_range(150, 600);
        end_kind   = $urandom_range(0, 6);
        recov_done = 1'b0;
        start_cnt  = bytes_in;
        next_cfg   = 250;
        while (bytes_in - start_cnt < RAND_BYTES) begin
            len = pick_len();
            if (!recov_done && recov_kind != 0 && bytes_in - start_cnt >= recov_at) begin
                recov_done = 1'b1;
                if (recov_kind == 1)
                    push_record(odd_type(), 32'd0, len, len);
                else
                    push_record(TYPE_RECORD, 32'($urandom_range(1, 8)), len, len);
            end else begin
                push_record(TYPE_RECORD, 32'd0, len, len);
            end
            send_feed();
            if (bytes_in - start_cnt >= next_cfg) begin
                drain();
                cfg_write(pick_base());
                next_cfg += 250;
            end
        end

        len = pick_len();
        case (end_kind)
            0: push_eoi();
            1: push_record(TYPE_FILE, 32'd0, len, len);
            2: begin
                push_bytes($urandom_range(1, HDR_BYTES - 1));
                push_eoi();
            end
            3: begin
                len = $urandom_range(1, 30);
                push_record(TYPE_RECORD, 32'd0, len, $urandom_range(0, len - 1));
                push_eoi();
            end
            4: begin
                prv = 32'($urandom_range(1000, 32'h7FFF_FFFF));
                push_word(TYPE_RECORD);
                push_word(prv);
                push_word(prv - 32'($urandom_range(0, 999)));
            end
            5: begin
                push_word(TYPE_RECORD);
                push_word(prior_next);
                push_word(last_next + 32'($urandom_range(0, HDR_BYTES - 1)));
            end
            default: begin
                // Failed recovery needs a first, patched fault.
                if (!in_recovery) begin
                    push_record(odd_type(), 32'd0, len, len);
                    send_feed();
                end
                k = $urandom_range(0, 1);
                if (k == 0)
                    push_record(odd_type(), 32'd0, len, len);
                else
                    push_record(TYPE_RECORD, 32'($urandom_range(1, 8)), len, len);
            end
        endcase
        send_feed();

        // Once stopped, the block repeats its final status for any input.
        for (int i = 0; i < 12; i++)
            feed_q.insert(feed_q.size(),
                          '{1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))});
        send_feed();
        drain();

        if (fail_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
